### rtl/slsf_pkg.sv
// ----------------------------------------------------------------------------
// slsf_pkg
// Lexer modes, character codes and status codes of the source flattener.
// ----------------------------------------------------------------------------
package slsf_pkg;

    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_GAP     = 3'd0;
    localparam t_mode MODE_COMMENT = 3'd1;
    localparam t_mode MODE_DIGITS  = 3'd2;
    localparam t_mode MODE_QUOTE   = 3'd3;
    localparam t_mode MODE_STRING  = 3'd4;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EARLY    = 2'd1;
    localparam t_status ST_UNMATCH  = 2'd2;
    localparam t_status ST_TOO_DEEP = 2'd3;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

### rtl/stack_language_source_flattener.sv
// ----------------------------------------------------------------------------
// stack_language_source_flattener
// Re-emits bracket-nested stack language source one token per line while the nest depth is within the threshold.
// ----------------------------------------------------------------------------
// One input beat is decoded in its accept cycle into a short plan (newline
// closing a digit run, indent count, token byte or comment newline marker,
// trailing newline, status). The plan is then walked in that order, with a
// down counter for the indent, loading one result beat per cycle into the
// output register while the output is not stalled: up to nest depth + 2 result beats for
// a token, one more when the token closes a digit run, four for a newline
// inside a comment. The input is not ready until the last result of the item
// has entered the output register; whitespace between tokens and input after
// an error give no result.
module stack_language_source_flattener #(
    parameter int MAX_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic [1:0] o_status,
    output logic       o_last,
    input  logic       i_cfg_wr_en,
    input  logic signed [6:0] i_cfg_wr_data
);

    localparam logic [5:0] MaxDepthW = 6'(MAX_DEPTH);

    logic signed [6:0]     r_flat;
    logic [5:0]            r_depth, n_depth;
    slsf_pkg::t_mode       r_mode, n_mode;
    logic                  r_halt, n_halt;

    logic                  r_pre, n_pre;
    logic [5:0]            r_cnt, n_cnt;
    logic                  r_byte, n_byte;
    logic [7:0]            r_b;
    logic                  r_cmt, n_cmt;
    logic [1:0]            r_ci, n_ci;
    logic                  r_post, n_post;
    logic                  r_st, n_st;
    slsf_pkg::t_status     r_code, n_code;

    logic                  busy, accept, emit;
    logic                  tok, is_sp, is_dig, eoi;
    logic [7:0]            b;
    logic [7:0]            e_byte;
    logic                  e_has, e_last;
    slsf_pkg::t_status     e_status;

    function automatic logic shown(input logic [5:0] d, input logic signed [6:0] thr);
        return $signed({1'b0, d}) <= thr;
    endfunction

    assign busy       = r_pre || (r_cnt != '0) || r_byte || r_cmt || r_post || r_st;
    assign o_in_ready = !busy;
    assign accept     = i_in_valid && o_in_ready;
    assign emit       = busy && (!o_out_valid || i_out_ready);

    assign b      = i_in_byte;
    assign eoi    = i_end_of_input;
    assign is_sp  = (b == slsf_pkg::CH_SPACE) ||
                    (b >= slsf_pkg::CH_TAB && b <= slsf_pkg::CH_CR);
    assign is_dig = (b >= slsf_pkg::CH_ZERO) && (b <= slsf_pkg::CH_NINE);

    always_comb begin
        n_depth = r_depth;
        n_mode  = r_mode;
        n_halt  = r_halt;
        n_pre   = r_pre;
        n_cnt   = r_cnt;
        n_byte  = r_byte;
        n_cmt   = r_cmt;
        n_ci    = r_ci;
        n_post  = r_post;
        n_st    = r_st;
        n_code  = r_code;
        tok     = 1'b0;

        if (accept && !r_halt) begin
            n_pre  = 1'b0;
            n_cnt  = '0;
            n_byte = 1'b0;
            n_cmt  = 1'b0;
            n_ci   = '0;
            n_post = 1'b0;
            n_st   = 1'b0;
            n_code = slsf_pkg::ST_OK;
            case (r_mode)
                slsf_pkg::MODE_COMMENT: begin
                    if (eoi) begin
                        n_st = 1'b1; n_code = slsf_pkg::ST_EARLY; n_halt = 1'b1;
                    end else if (b == slsf_pkg::CH_RBRACE) begin
                        n_byte = 1'b1;
                        n_mode = slsf_pkg::MODE_GAP;
                        n_post = shown(r_depth, r_flat);
                    end else if (b == slsf_pkg::CH_NL) begin
                        n_cmt = 1'b1;
                    end else begin
                        n_byte = 1'b1;
                    end
                end
                slsf_pkg::MODE_STRING: begin
                    if (eoi) begin
                        n_st = 1'b1; n_code = slsf_pkg::ST_EARLY; n_halt = 1'b1;
                    end else begin
                        n_byte = 1'b1;
                        if (b == slsf_pkg::CH_DQUOTE) begin
                            n_mode = slsf_pkg::MODE_GAP;
                            n_post = shown(r_depth, r_flat);
                        end
                    end
                end
                slsf_pkg::MODE_QUOTE: begin
                    if (eoi) begin
                        n_st = 1'b1; n_code = slsf_pkg::ST_EARLY; n_halt = 1'b1;
                    end else begin
                        n_byte = 1'b1;
                        n_mode = slsf_pkg::MODE_GAP;
                        n_post = shown(r_depth, r_flat);
                    end
                end
                slsf_pkg::MODE_DIGITS: begin
                    if (!eoi && is_dig) begin
                        n_byte = 1'b1;
                    end else begin
                        n_pre  = shown(r_depth, r_flat);
                        n_mode = slsf_pkg::MODE_GAP;
                        tok    = 1'b1;
                    end
                end
                default: begin
                    n_mode = slsf_pkg::MODE_GAP;
                    tok    = 1'b1;
                end
            endcase

            if (tok) begin
                if (eoi) begin
                    n_st = 1'b1;
                    if (r_depth != '0) begin
                        n_code = slsf_pkg::ST_EARLY; n_halt = 1'b1;
                    end
                end else if (is_sp) begin
                    n_st = 1'b0;
                end else if (b == slsf_pkg::CH_RBRACK && r_depth == '0) begin
                    n_st = 1'b1; n_code = slsf_pkg::ST_UNMATCH; n_halt = 1'b1;
                end else if (b == slsf_pkg::CH_LBRACK && r_depth >= MaxDepthW) begin
                    n_st = 1'b1; n_code = slsf_pkg::ST_TOO_DEEP; n_halt = 1'b1;
                end else begin
                    if (shown(r_depth, r_flat)) begin
                        n_cnt = r_depth - {5'd0, b == slsf_pkg::CH_RBRACK};
                    end
                    n_byte = 1'b1;
                    if (b == slsf_pkg::CH_LBRACE) begin
                        n_mode = slsf_pkg::MODE_COMMENT;
                    end else if (b == slsf_pkg::CH_LBRACK) begin
                        n_depth = r_depth + 6'd1;
                        n_post  = shown(r_depth + 6'd1, r_flat);
                    end else if (b == slsf_pkg::CH_RBRACK) begin
                        n_depth = r_depth - 6'd1;
                        n_post  = shown(r_depth - 6'd1, r_flat);
                    end else if (is_dig) begin
                        n_mode = slsf_pkg::MODE_DIGITS;
                    end else if (b == slsf_pkg::CH_SQUOTE) begin
                        n_mode = slsf_pkg::MODE_QUOTE;
                    end else if (b == slsf_pkg::CH_DQUOTE) begin
                        n_mode = slsf_pkg::MODE_STRING;
                    end else begin
                        n_post = shown(r_depth, r_flat);
                    end
                end
            end
        end

        e_byte   = 8'd0;
        e_has    = 1'b1;
        e_status = slsf_pkg::ST_OK;
        e_last   = 1'b0;
        if (emit) begin
            if (r_pre) begin
                e_byte = slsf_pkg::CH_NL;
                e_last = !((r_cnt != '0) || r_byte || r_cmt || r_post || r_st);
                n_pre  = 1'b0;
            end else if (r_cnt != '0) begin
                e_byte = slsf_pkg::CH_SPACE;
                e_last = !((r_cnt != 6'd1) || r_byte || r_cmt || r_post || r_st);
                n_cnt  = r_cnt - 6'd1;
            end else if (r_byte) begin
                e_byte = r_b;
                e_last = !(r_cmt || r_post || r_st);
                n_byte = 1'b0;
            end else if (r_cmt) begin
                e_byte = (r_ci == 2'd1 || r_ci == 2'd2) ? slsf_pkg::CH_SLASH
                                                        : slsf_pkg::CH_SPACE;
                e_last = (r_ci == 2'd3) && !(r_post || r_st);
                n_ci   = r_ci + 2'd1;
                n_cmt  = (r_ci != 2'd3);
            end else if (r_post) begin
                e_byte = slsf_pkg::CH_NL;
                e_last = !r_st;
                n_post = 1'b0;
            end else begin
                e_has    = 1'b0;
                e_status = r_code;
                e_last   = 1'b1;
                n_st     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat      <= '0;
            r_depth     <= '0;
            r_mode      <= slsf_pkg::MODE_GAP;
            r_halt      <= 1'b0;
            r_pre       <= 1'b0;
            r_cnt       <= '0;
            r_byte      <= 1'b0;
            r_cmt       <= 1'b0;
            r_ci        <= '0;
            r_post      <= 1'b0;
            r_st        <= 1'b0;
            r_code      <= slsf_pkg::ST_OK;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_flat <= i_cfg_wr_data;
            end
            r_depth <= n_depth;
            r_mode  <= n_mode;
            r_halt  <= n_halt;
            r_pre   <= n_pre;
            r_cnt   <= n_cnt;
            r_byte  <= n_byte;
            r_cmt   <= n_cmt;
            r_ci    <= n_ci;
            r_post  <= n_post;
            r_st    <= n_st;
            r_code  <= n_code;
            if (emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b <= b;
        end
        if (emit) begin
            o_out_byte <= e_byte;
            o_has_byte <= e_has;
            o_status   <= e_status;
            o_last     <= e_last;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= MaxDepthW)
        else $error("nest depth beyond limit");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_halt) |=> !busy)
        else $error("result planned while halted");

    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != slsf_pkg::ST_OK) |-> (!o_has_byte && o_last))
        else $error("error status on a byte beat");

    a_cmt_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ci != 2'd0) |-> r_cmt)
        else $error("comment marker index without marker");

endmodule

### tb/sv/stack_language_source_flattener_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_language_source_flattener_check
// Watches the input, output and threshold ports of the source flattener,
// predicts every output beat from the accepted input beats and compares the
// accepted output beats field by field in order.
// ----------------------------------------------------------------------------
module stack_language_source_flattener_check #(
    parameter int MAX_DEPTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end_of_input,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [7:0]        i_out_byte,
    input  logic              i_has_byte,
    input  logic [1:0]        i_status,
    input  logic              i_last,
    input  logic              i_cfg_wr_en,
    input  logic signed [6:0] i_cfg_wr_data,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              has_byte;
        slsf_pkg::t_status status;
        logic              last;
    } t_beat;

    t_beat             beats_due[$];
    t_beat             item_beats[$];
    logic signed [6:0] flat_thr;
    int                nest;
    slsf_pkg::t_mode   mode;
    logic              halted;
    int                errors = 0;

    function automatic void push_beat(logic [7:0] b, logic has, slsf_pkg::t_status st);
        t_beat x;
        x.out_byte = b;
        x.has_byte = has;
        x.status   = st;
        x.last     = 1'b0;
        item_beats.push_back(x);
    endfunction

    function automatic bit indented();
        return nest <= int'(flat_thr);
    endfunction

    function automatic void halt_with(slsf_pkg::t_status st);
        halted = 1'b1;
        push_beat(8'h00, 1'b0, st);
    endfunction

    function automatic void newline_if_shown();
        if (indented())
            push_beat(slsf_pkg::CH_NL, 1'b1, slsf_pkg::ST_OK);
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == slsf_pkg::CH_SPACE ||
               (b >= slsf_pkg::CH_TAB && b <= slsf_pkg::CH_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= slsf_pkg::CH_ZERO && b <= slsf_pkg::CH_NINE;
    endfunction

    function automatic void open_token(logic [7:0] b, logic eoi);
        int pad;
        if (eoi) begin
            if (nest > 0)
                halt_with(slsf_pkg::ST_EARLY);
            else
                push_beat(8'h00, 1'b0, slsf_pkg::ST_OK);
            return;
        end
        if (is_blank(b))
            return;
        if (b == slsf_pkg::CH_RBRACK && nest == 0) begin
            halt_with(slsf_pkg::ST_UNMATCH);
            return;
        end
        if (b == slsf_pkg::CH_LBRACK && nest >= MAX_DEPTH) begin
            halt_with(slsf_pkg::ST_TOO_DEEP);
            return;
        end
        if (indented()) begin
            pad = nest - ((b == slsf_pkg::CH_RBRACK) ? 1 : 0);
            repeat (pad) push_beat(slsf_pkg::CH_SPACE, 1'b1, slsf_pkg::ST_OK);
        end
        push_beat(b, 1'b1, slsf_pkg::ST_OK);
        if (b == slsf_pkg::CH_LBRACE) begin
            mode = slsf_pkg::MODE_COMMENT;
        end else if (b == slsf_pkg::CH_LBRACK) begin
            nest++;
            newline_if_shown();
        end else if (b == slsf_pkg::CH_RBRACK) begin
            nest--;
            newline_if_shown();
        end else if (is_digit(b)) begin
            mode = slsf_pkg::MODE_DIGITS;
        end else if (b == slsf_pkg::CH_SQUOTE) begin
            mode = slsf_pkg::MODE_QUOTE;
        end else if (b == slsf_pkg::CH_DQUOTE) begin
            mode = slsf_pkg::MODE_STRING;
        end else begin
            newline_if_shown();
        end
    endfunction

    function automatic void flatten_beat(logic [7:0] b, logic eoi);
        t_beat tail;
        item_beats.delete();
        if (halted)
            return;
        case (mode)
            slsf_pkg::MODE_COMMENT: begin
                if (eoi) begin
                    halt_with(slsf_pkg::ST_EARLY);
                end else if (b == slsf_pkg::CH_RBRACE) begin
                    push_beat(b, 1'b1, slsf_pkg::ST_OK);
                    mode = slsf_pkg::MODE_GAP;
                    newline_if_shown();
                end else if (b == slsf_pkg::CH_NL) begin
                    push_beat(slsf_pkg::CH_SPACE, 1'b1, slsf_pkg::ST_OK);
                    push_beat(slsf_pkg::CH_SLASH, 1'b1, slsf_pkg::ST_OK);
                    push_beat(slsf_pkg::CH_SLASH, 1'b1, slsf_pkg::ST_OK);
                    push_beat(slsf_pkg::CH_SPACE, 1'b1, slsf_pkg::ST_OK);
                end else begin
                    push_beat(b, 1'b1, slsf_pkg::ST_OK);
                end
            end
            slsf_pkg::MODE_STRING: begin
                if (eoi) begin
                    halt_with(slsf_pkg::ST_EARLY);
                end else begin
                    push_beat(b, 1'b1, slsf_pkg::ST_OK);
                    if (b == slsf_pkg::CH_DQUOTE) begin
                        mode = slsf_pkg::MODE_GAP;
                        newline_if_shown();
                    end
                end
            end
            slsf_pkg::MODE_QUOTE: begin
                if (eoi) begin
                    halt_with(slsf_pkg::ST_EARLY);
                end else begin
                    push_beat(b, 1'b1, slsf_pkg::ST_OK);
                    mode = slsf_pkg::MODE_GAP;
                    newline_if_shown();
                end
            end
            slsf_pkg::MODE_DIGITS: begin
                if (!eoi && is_digit(b)) begin
                    push_beat(b, 1'b1, slsf_pkg::ST_OK);
                end else begin
                    newline_if_shown();
                    mode = slsf_pkg::MODE_GAP;
                    open_token(b, eoi);
                end
            end
            default: begin
                mode = slsf_pkg::MODE_GAP;
                open_token(b, eoi);
            end
        endcase
        if (item_beats.size() > 0) begin
            tail = item_beats.pop_back();
            tail.last = 1'b1;
            item_beats.push_back(tail);
        end
        foreach (item_beats[k])
            beats_due.push_back(item_beats[k]);
    endfunction

    function automatic void check_beat(t_beat got);
        t_beat want;
        if (beats_due.size() == 0) begin
            $error("unexpected beat: out_byte %0h has_byte %0b status %0d last %0b",
                   got.out_byte, got.has_byte, got.status, got.last);
            errors++;
            return;
        end
        want = beats_due.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte expected %0h, actual %0h", want.out_byte, got.out_byte);
            errors++;
        end
        if (got.has_byte !== want.has_byte) begin
            $error("has_byte expected %0b, actual %0b", want.has_byte, got.has_byte);
            errors++;
        end
        if (got.status !== want.status) begin
            $error("status expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last expected %0b, actual %0b", want.last, got.last);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flat_thr = '0;
            nest     = 0;
            mode     = slsf_pkg::MODE_GAP;
            halted   = 1'b0;
            beats_due.delete();
        end else begin
            if (i_cfg_wr_en)
                flat_thr = i_cfg_wr_data;
            if (i_in_valid && i_in_ready)
                flatten_beat(i_in_byte, i_end_of_input);
            if (i_out_valid && i_out_ready)
                check_beat({i_out_byte, i_has_byte, i_status, i_last});
        end
        o_errors  = errors;
        o_pending = beats_due.size();
    end

endmodule

### tb/sv/stack_language_source_flattener_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_language_source_flattener_test
// Feeds the source flattener directed and random bracket-nested programs
// under several indentation thresholds, with random idle bursts on both
// channels, and ends the run on one fault that halts the block.
// ----------------------------------------------------------------------------
module stack_language_source_flattener_test;

    localparam int MAX_DEPTH   = 32;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 8;
    localparam int ITEM_BUDGET = 380;
    localparam int CALM_ITEMS  = 100;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_ready;
    logic [7:0]        in_byte       = 8'h00;
    logic              end_of_input  = 1'b0;
    logic              out_valid;
    logic              out_ready     = 1'b0;
    logic [7:0]        out_byte;
    logic              has_byte;
    logic [1:0]        status;
    logic              last;
    logic              cfg_wr_en     = 1'b0;
    logic signed [6:0] cfg_wr_data   = '0;

    int errors;
    int pending;
    int items_sent   = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    stack_language_source_flattener #(
        .MAX_DEPTH(MAX_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .i_end_of_input(end_of_input),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_byte    (out_byte),
        .o_has_byte    (has_byte),
        .o_status      (status),
        .o_last        (last),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    stack_language_source_flattener_check #(
        .MAX_DEPTH(MAX_DEPTH)
    ) check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_byte     (in_byte),
        .i_end_of_input(end_of_input),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_byte    (out_byte),
        .i_has_byte    (has_byte),
        .i_status      (status),
        .i_last        (last),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            stall_left <= $urandom_range(8, 0);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("stack_language_source_flattener_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(logic [7:0] b, logic eoi);
        int gap;
        if ($urandom_range(99) < gap_pct) begin
            gap = $urandom_range(9, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        in_byte      <= b;
        end_of_input <= eoi;
        do @(negedge i_clk); while (!in_ready);
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_eoi();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // hold off until every beat is out and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic signed [6:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic bit plain(logic [7:0] b);
        return !(b == slsf_pkg::CH_SPACE ||
                 (b >= slsf_pkg::CH_TAB && b <= slsf_pkg::CH_CR) ||
                 (b >= slsf_pkg::CH_ZERO && b <= slsf_pkg::CH_NINE) ||
                 b == slsf_pkg::CH_LBRACE || b == slsf_pkg::CH_LBRACK ||
                 b == slsf_pkg::CH_RBRACK || b == slsf_pkg::CH_DQUOTE ||
                 b == slsf_pkg::CH_SQUOTE);
    endfunction

    task automatic send_blank();
        if ($urandom_range(1) != 0)
            send_item(slsf_pkg::CH_SPACE, 1'b0);
        else
            send_item(8'($urandom_range(slsf_pkg::CH_CR, slsf_pkg::CH_TAB)), 1'b0);
    endtask

    task automatic send_word();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (!plain(b));
        send_item(b, 1'b0);
    endtask

    task automatic send_digits();
        repeat ($urandom_range(4, 1))
            send_item(8'($urandom_range(slsf_pkg::CH_NINE, slsf_pkg::CH_ZERO)), 1'b0);
    endtask

    task automatic send_comment();
        logic [7:0] b;
        send_item(slsf_pkg::CH_LBRACE, 1'b0);
        repeat ($urandom_range(6)) begin
            if ($urandom_range(4) == 0)
                b = slsf_pkg::CH_NL;
            else
                do b = 8'($urandom_range(255)); while (b == slsf_pkg::CH_RBRACE);
            send_item(b, 1'b0);
        end
        send_item(slsf_pkg::CH_RBRACE, 1'b0);
    endtask

    task automatic send_string();
        logic [7:0] b;
        send_item(slsf_pkg::CH_DQUOTE, 1'b0);
        repeat ($urandom_range(5)) begin
            do b = 8'($urandom_range(255)); while (b == slsf_pkg::CH_DQUOTE);
            send_item(b, 1'b0);
        end
        send_item(slsf_pkg::CH_DQUOTE, 1'b0);
    endtask

    task automatic send_program(int tokens, int depth_cap);
        int level;
        level = 0;
        repeat (tokens) begin
            case ($urandom_range(9))
                0, 1: begin
                    if (level < depth_cap) begin
                        send_item(slsf_pkg::CH_LBRACK, 1'b0);
                        level++;
                    end else begin
                        send_word();
                    end
                end
                2, 3: begin
                    if (level > 0) begin
                        send_item(slsf_pkg::CH_RBRACK, 1'b0);
                        level--;
                    end else begin
                        send_word();
                    end
                end
                4: send_comment();
                5: send_string();
                6: begin
                    send_item(slsf_pkg::CH_SQUOTE, 1'b0);
                    send_item(8'($urandom_range(255)), 1'b0);
                end
                7: send_digits();
                default: send_word();
            endcase
            if ($urandom_range(2) == 0)
                send_blank();
        end
        while (level > 0) begin
            send_item(slsf_pkg::CH_RBRACK, 1'b0);
            level--;
        end
        send_eoi();
    endtask

    task automatic send_nest(int levels);
        repeat (levels) begin
            send_item(slsf_pkg::CH_LBRACK, 1'b0);
            if ($urandom_range(3) == 0)
                send_word();
        end
        send_digits();
        repeat (levels) send_item(slsf_pkg::CH_RBRACK, 1'b0);
        send_eoi();
    endtask

    function automatic logic signed [6:0] pick_threshold();
        case ($urandom_range(5))
            0: return -7'sd64;
            1: return -7'sd1;
            2: return 7'sd0;
            3: return 7'sd63;
            default: return 7'($urandom_range(127));
        endcase
    endfunction

    task automatic send_fault();
        case ($urandom_range(6))
            0: send_item(slsf_pkg::CH_RBRACK, 1'b0);
            1: repeat (MAX_DEPTH + 1) send_item(slsf_pkg::CH_LBRACK, 1'b0);
            2: begin
                send_item(slsf_pkg::CH_LBRACE, 1'b0);
                send_item("a", 1'b0);
                send_eoi();
            end
            3: begin
                send_item(slsf_pkg::CH_DQUOTE, 1'b0);
                send_item("a", 1'b0);
                send_eoi();
            end
            4: begin
                send_item(slsf_pkg::CH_SQUOTE, 1'b0);
                send_eoi();
            end
            5: begin
                send_item(slsf_pkg::CH_LBRACK, 1'b0);
                send_item("a", 1'b0);
                send_eoi();
            end
            default: begin
                send_item(slsf_pkg::CH_LBRACK, 1'b0);
                send_item("5", 1'b0);
                send_eoi();
            end
        endcase
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(slsf_pkg::CH_LBRACK, 1'b0);
        send_item("a", 1'b0);
        send_item(slsf_pkg::CH_RBRACK, 1'b0);
        send_eoi();
        drain();

        set_threshold(7'sd2);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(slsf_pkg::CH_LBRACK, 1'b0);
        send_item("7", 1'b0);
        send_item("9", 1'b0);
        send_item(slsf_pkg::CH_LBRACK, 1'b0);
        send_item(slsf_pkg::CH_LBRACE, 1'b0);
        send_item("x", 1'b0);
        send_item(slsf_pkg::CH_NL, 1'b0);
        send_item(slsf_pkg::CH_RBRACE, 1'b0);
        send_item(slsf_pkg::CH_DQUOTE, 1'b0);
        send_item(slsf_pkg::CH_SPACE, 1'b0);
        send_item(slsf_pkg::CH_DQUOTE, 1'b0);
        send_item(slsf_pkg::CH_RBRACK, 1'b0);
        send_item(slsf_pkg::CH_SQUOTE, 1'b0);
        send_item(slsf_pkg::CH_RBRACK, 1'b0);
        send_item(slsf_pkg::CH_RBRACK, 1'b0);
        send_eoi();
        send_item("5", 1'b0);
        send_eoi();
        drain();

        set_threshold(7'sd63);
        gap_pct   = 20;
        stall_pct = 20;
        send_nest(MAX_DEPTH);
        drain();

        while (items_sent < ITEM_BUDGET - CALM_ITEMS) begin
            gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 10);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(50, 10);
            set_threshold(pick_threshold());
            send_program($urandom_range(40, 8),
                         ($urandom_range(5) == 0) ? MAX_DEPTH : $urandom_range(4, 1));
            drain();
        end

        // drop all idling for the tail of the run
        gap_pct   = 0;
        stall_pct = 0;
        set_threshold(pick_threshold());
        send_program(30, 3);
        drain();
        send_fault();
        repeat (4) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        drain();

        if (errors == 0)
            $display("stack_language_source_flattener_test OK");
        else
            $display("stack_language_source_flattener_test NOT OK");
        $finish;
    end

endmodule
